[rtl/palette_nearest_color_matcher_defines.svh]
// assertion macros shared by the palette color matcher rtl
// no dependencies; included by files that carry concurrent checks
`ifndef PALETTE_NEAREST_COLOR_MATCHER_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_MATCHER_DEFINES_SVH

// same-cycle implication, off while in reset
`define PNC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define PNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pnc_pkg.sv]
// types and constants of the palette color matcher
// no dependencies; used by every module of the block
`default_nettype none

package pnc_pkg;

    typedef enum logic [1:0] {
        CMD_MATCH   = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_BLACK    = 3'd0,
        CFG_WHITE    = 3'd1,
        CFG_CAPACITY = 3'd2,
        CFG_SPAN     = 3'd3,
        CFG_ALLOC    = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BS_ADDR,
        S_BS_CMP,
        S_WB_ADDR,
        S_WB_CMP,
        S_SC_ADDR,
        S_SC_KEY,
        S_SC_DIST,
        S_SC_END,
        S_IN_ADDR,
        S_IN_CMP,
        S_SH_ADDR,
        S_SH_WR,
        S_IN_PUT,
        S_REV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [17:0] key;
        logic [7:0]  slot;
    } t_key_entry;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_rgb;

    localparam logic [31:0] ARGB_BLACK  = 32'hFF00_0000;
    localparam logic [31:0] ARGB_WHITE  = 32'hFFFF_FFFF;
    localparam logic [31:0] COLOR_MISS  = 32'hFF00_0000;
    localparam logic [17:0] DIST_NONE   = 18'h3FFFF;

    localparam logic [7:0]  RST_BLACK    = 8'd0;
    localparam logic [7:0]  RST_WHITE    = 8'd1;
    localparam logic [8:0]  RST_CAPACITY = 9'd256;
    localparam logic [17:0] RST_SPAN     = 18'd20000;
    localparam logic [17:0] RST_ALLOC    = 18'd20000;

endpackage

`default_nettype wire

[rtl/pnc_key_store.sv]
// sorted order list: sum key and slot per position, one write and one read port
// depends on pnc_pkg for the entry type
`default_nettype none

module pnc_key_store
    import pnc_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire [$clog2(ENTRIES)-1:0]    i_waddr,
    input  t_key_entry                   i_wdata,
    input  wire [$clog2(ENTRIES)-1:0]    i_raddr,
    output t_key_entry                   o_rdata
);

    t_key_entry r_mem [ENTRIES];
    t_key_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/pnc_color_store.sv]
// palette color table: 48-bit rgb per slot, one write and one read port
// depends on pnc_pkg for the color type
`default_nettype none

module pnc_color_store
    import pnc_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire [$clog2(ENTRIES)-1:0]    i_waddr,
    input  t_rgb                         i_wdata,
    input  wire [$clog2(ENTRIES)-1:0]    i_raddr,
    output t_rgb                         o_rdata
);

    t_rgb r_mem [ENTRIES];
    t_rgb r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/pnc_dist.sv]
// manhattan distance between query color and a palette color
// depends on pnc_pkg for the color type
`default_nettype none

module pnc_dist
    import pnc_pkg::*;
(
    input  t_rgb        i_query,
    input  t_rgb        i_entry,
    output logic [17:0] o_dist
);

    logic [15:0] d_red;
    logic [15:0] d_green;
    logic [15:0] d_blue;

    always_comb begin
        d_red   = (i_query.red > i_entry.red) ? i_query.red - i_entry.red
                                              : i_entry.red - i_query.red;
        d_green = (i_query.green > i_entry.green) ? i_query.green - i_entry.green
                                                  : i_entry.green - i_query.green;
        d_blue  = (i_query.blue > i_entry.blue) ? i_query.blue - i_entry.blue
                                                : i_entry.blue - i_query.blue;
        o_dist  = {2'b00, d_red} + {2'b00, d_green} + {2'b00, d_blue};
    end

endmodule

`default_nettype wire

[rtl/palette_nearest_color_matcher.sv]
// Palette nearest color matcher, top level with the command sequencer
//
// Usage: raise i_start with i_cmd and the request fields; the request is
// taken when o_busy is low. Commands: match an ARGB color to a pixel,
// insert a palette entry into the sum-sorted order list, and reverse
// lookup of a pixel's color. Exactly one result per request comes back
// with o_valid high for one cycle; the receiver cannot stall it, and
// o_busy drops in the cycle after the result.
// The order and palette memories have registered (synchronous) reads.
// Reverse lookup reads the palette memory; shortcuts, misses and rejects
// go straight to the result. Match runs a binary search over the order
// list, walks back over equal keys and scans the window entries through
// the single order memory read port. Insert compares keys, shifts the
// larger order entries up and then puts the new key.
// One request is worked on at a time. Configuration writes on i_cfg_we
// are taken at any edge and belong to idle periods.
// Reset clears the entry count and loads register defaults; memories are
// not cleared, the user must not read unwritten entries (not enforced).
`default_nettype none

module palette_nearest_color_matcher
    import pnc_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [1:0]  i_cmd,
    input  wire  [7:0]  i_pixel_index,
    input  wire  [31:0] i_argb,
    input  wire  [15:0] i_entry_red,
    input  wire  [15:0] i_entry_green,
    input  wire  [15:0] i_entry_blue,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [17:0] i_cfg_wdata,
    output logic        o_valid,
    output logic [7:0]  o_pixel,
    output logic        o_found,
    output logic [17:0] o_distance,
    output logic        o_alloc_wanted,
    output logic [17:0] o_key_sum,
    output logic [31:0] o_color_out
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    t_state r_state, n_state;

    logic [7:0]  r_black, r_white;
    logic [8:0]  r_cap;
    logic [17:0] r_span, r_thr;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i, r_i0, n_i0, r_i1, n_i1;
    t_cmd          r_cmd, n_cmd;
    logic [17:0]   r_cur_key, n_cur_key;
    logic [17:0]   r_sum, n_sum;
    logic [18:0]   r_hi, n_hi;
    logic [17:0]   r_lo, n_lo;
    logic [23:0]   r_q, n_q;
    logic [7:0]    r_slot, n_slot;
    logic          r_got, n_got;
    logic [7:0]    r_best, n_best;
    logic [17:0]   r_mind, n_mind;
    logic [7:0]    r_pixel, n_pixel;
    logic          r_found, n_found;
    logic [17:0]   r_dist, n_dist;
    logic          r_alloc, n_alloc;
    logic [17:0]   r_key_sum, n_key_sum;
    logic [31:0]   r_color, n_color;

    logic            key_we;
    logic [AW-1:0]   key_waddr, key_raddr;
    t_key_entry      key_wdata, key_rd;
    logic            pal_we;
    logic [AW-1:0]   pal_waddr, pal_raddr;
    t_rgb            pal_wdata, pal_rd;
    t_rgb            query_rgb;
    logic [17:0]     scan_dist;

    logic          accept;
    logic [17:0]   q_sum, ins_sum;
    logic [CW-1:0] bs_width, bs_mid, i_less, i_more, i1_less;
    logic          slot_ok, table_full, rev_hit, is_black, is_white;
    logic          scan_take;

    pnc_key_store #(.ENTRIES(ENTRIES)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rd)
    );

    pnc_color_store #(.ENTRIES(ENTRIES)) u_colors (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (pal_wdata),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rd)
    );

    assign query_rgb = '{red: {r_q[23:16], 8'h00}, green: {r_q[15:8], 8'h00},
                         blue: {r_q[7:0], 8'h00}};

    pnc_dist u_dist (
        .i_query (query_rgb),
        .i_entry (pal_rd),
        .o_dist  (scan_dist)
    );

    assign accept     = i_start && (r_state == S_IDLE);
    assign q_sum      = {2'b00, i_argb[23:16], 8'h00} + {2'b00, i_argb[15:8], 8'h00}
                      + {2'b00, i_argb[7:0], 8'h00};
    assign ins_sum    = {2'b00, i_entry_red} + {2'b00, i_entry_green}
                      + {2'b00, i_entry_blue};
    assign slot_ok    = {1'b0, i_pixel_index} < 9'(ENTRIES);
    assign table_full = r_count == CW'(ENTRIES);
    assign rev_hit    = {1'b0, i_pixel_index} < 9'(r_count);
    assign is_black   = i_argb == ARGB_BLACK;
    assign is_white   = i_argb == ARGB_WHITE;
    assign bs_width   = r_i1 - r_i0;
    assign bs_mid     = r_i0 + (bs_width >> 1);
    assign i_less     = r_i - 1'b1;
    assign i_more     = r_i + 1'b1;
    assign i1_less    = r_i1 - 1'b1;
    assign scan_take  = (scan_dist == 18'd0) || !r_got || (scan_dist < r_mind);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black <= RST_BLACK;
            r_white <= RST_WHITE;
            r_cap   <= RST_CAPACITY;
            r_span  <= RST_SPAN;
            r_thr   <= RST_ALLOC;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_BLACK:    r_black <= i_cfg_wdata[7:0];
                CFG_WHITE:    r_white <= i_cfg_wdata[7:0];
                CFG_CAPACITY: r_cap   <= i_cfg_wdata[8:0];
                CFG_SPAN:     r_span  <= i_cfg_wdata;
                CFG_ALLOC:    r_thr   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_i0      <= n_i0;
        r_i1      <= n_i1;
        r_cmd     <= n_cmd;
        r_cur_key <= n_cur_key;
        r_sum     <= n_sum;
        r_hi      <= n_hi;
        r_lo      <= n_lo;
        r_q       <= n_q;
        r_slot    <= n_slot;
        r_got     <= n_got;
        r_best    <= n_best;
        r_mind    <= n_mind;
        r_pixel   <= n_pixel;
        r_found   <= n_found;
        r_dist    <= n_dist;
        r_alloc   <= n_alloc;
        r_key_sum <= n_key_sum;
        r_color   <= n_color;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_MATCH: begin
                            if (is_black || is_white) begin
                                n_state = S_DONE;
                            end else if (q_sum > r_span) begin
                                n_state = S_BS_ADDR;
                            end else begin
                                n_state = S_SC_ADDR;
                            end
                        end
                        CMD_INSERT: begin
                            n_state = (slot_ok && !table_full) ? S_IN_ADDR : S_DONE;
                        end
                        CMD_REVERSE: n_state = rev_hit ? S_REV : S_DONE;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_BS_ADDR: n_state = (bs_width > CW'(1)) ? S_BS_CMP : S_WB_ADDR;
            S_BS_CMP:  n_state = (key_rd.key == r_lo) ? S_WB_ADDR : S_BS_ADDR;
            S_WB_ADDR: n_state = (r_i != '0) ? S_WB_CMP : S_SC_ADDR;
            S_WB_CMP:  n_state = (key_rd.key == r_cur_key) ? S_WB_ADDR : S_SC_ADDR;
            S_SC_ADDR: n_state = (r_i < r_count) ? S_SC_KEY : S_SC_END;
            S_SC_KEY:  n_state = ({1'b0, key_rd.key} > r_hi) ? S_SC_END : S_SC_DIST;
            S_SC_DIST: n_state = (scan_dist == 18'd0) ? S_SC_END : S_SC_ADDR;
            S_SC_END:  n_state = S_DONE;
            S_IN_ADDR: n_state = (r_i < r_count) ? S_IN_CMP : S_SH_ADDR;
            S_IN_CMP:  n_state = (key_rd.key > r_sum) ? S_SH_ADDR : S_IN_ADDR;
            S_SH_ADDR: n_state = (r_i1 > r_i) ? S_SH_WR : S_IN_PUT;
            S_SH_WR:   n_state = S_SH_ADDR;
            S_IN_PUT:  n_state = S_DONE;
            S_REV:     n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        n_count   = r_count;
        n_i       = r_i;
        n_i0      = r_i0;
        n_i1      = r_i1;
        n_cmd     = r_cmd;
        n_cur_key = r_cur_key;
        n_sum     = r_sum;
        n_hi      = r_hi;
        n_lo      = r_lo;
        n_q       = r_q;
        n_slot    = r_slot;
        n_got     = r_got;
        n_best    = r_best;
        n_mind    = r_mind;
        n_pixel   = r_pixel;
        n_found   = r_found;
        n_dist    = r_dist;
        n_alloc   = r_alloc;
        n_key_sum = r_key_sum;
        n_color   = r_color;
        key_we    = 1'b0;
        key_waddr = r_i[AW-1:0];
        key_wdata = key_rd;
        key_raddr = r_i[AW-1:0];
        pal_we    = 1'b0;
        pal_waddr = i_pixel_index[AW-1:0];
        pal_wdata = '{red: i_entry_red, green: i_entry_green, blue: i_entry_blue};
        pal_raddr = i_pixel_index[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd     = t_cmd'(i_cmd);
                    n_pixel   = 8'd0;
                    n_found   = 1'b0;
                    n_dist    = 18'd0;
                    n_alloc   = 1'b0;
                    n_key_sum = 18'd0;
                    n_color   = 32'd0;
                    n_got     = 1'b0;
                    n_best    = 8'd0;
                    n_mind    = 18'd0;
                    n_i       = '0;
                    n_i0      = '0;
                    n_i1      = r_count;
                    n_q       = i_argb[23:0];
                    n_slot    = i_pixel_index;
                    unique case (t_cmd'(i_cmd))
                        CMD_MATCH: begin
                            n_dist = DIST_NONE;
                            n_sum  = q_sum;
                            n_hi   = {1'b0, q_sum} + {1'b0, r_span};
                            n_lo   = q_sum - r_span;
                            if (is_black) begin
                                n_pixel = r_black;
                            end else if (is_white) begin
                                n_pixel = r_white;
                            end
                        end
                        CMD_INSERT: begin
                            n_key_sum = ins_sum;
                            n_sum     = ins_sum;
                            pal_we    = slot_ok;
                        end
                        CMD_REVERSE: begin
                            n_color = COLOR_MISS;
                        end
                        default: ;
                    endcase
                end
            end
            S_BS_ADDR: begin
                if (bs_width > CW'(1)) begin
                    n_i       = bs_mid;
                    key_raddr = bs_mid[AW-1:0];
                end
            end
            S_BS_CMP: begin
                n_cur_key = key_rd.key;
                if (key_rd.key < r_lo) begin
                    n_i0 = r_i;
                end else if (key_rd.key > r_lo) begin
                    n_i1 = r_i;
                end
            end
            S_WB_ADDR: key_raddr = i_less[AW-1:0];
            S_WB_CMP: begin
                // step back over keys equal to the one found
                if (key_rd.key == r_cur_key) begin
                    n_i = i_less;
                end
            end
            S_SC_ADDR: key_raddr = r_i[AW-1:0];
            S_SC_KEY: begin
                pal_raddr = key_rd.slot[AW-1:0];
                n_slot    = key_rd.slot;
            end
            S_SC_DIST: begin
                if (scan_take) begin
                    n_mind = scan_dist;
                    n_best = r_slot;
                    n_got  = 1'b1;
                end
                n_i = i_more;
            end
            S_SC_END: begin
                n_pixel = r_got ? r_best : 8'd0;
                n_found = r_got;
                n_dist  = r_got ? r_mind : DIST_NONE;
                n_alloc = (!r_got || (r_mind > r_thr)) && (9'(r_count) < r_cap);
            end
            S_IN_ADDR: key_raddr = r_i[AW-1:0];
            S_IN_CMP: begin
                if (key_rd.key <= r_sum) begin
                    n_i = i_more;
                end
            end
            S_SH_ADDR: key_raddr = i1_less[AW-1:0];
            S_SH_WR: begin
                // move entry k-1 up to k
                key_we    = 1'b1;
                key_waddr = r_i1[AW-1:0];
                key_wdata = key_rd;
                n_i1      = i1_less;
            end
            S_IN_PUT: begin
                key_we    = 1'b1;
                key_waddr = r_i[AW-1:0];
                key_wdata = '{key: r_sum, slot: r_slot};
                n_count   = r_count + 1'b1;
            end
            S_REV: begin
                n_color = {8'hFF, pal_rd.red[15:8], pal_rd.green[15:8], pal_rd.blue[15:8]};
            end
            S_DONE: ;
            default: ;
        endcase
    end

    assign o_busy         = r_state != S_IDLE;
    assign o_valid        = r_state == S_DONE;
    assign o_pixel        = r_pixel;
    assign o_found        = r_found;
    assign o_distance     = r_dist;
    assign o_alloc_wanted = r_alloc;
    assign o_key_sum      = r_key_sum;
    assign o_color_out    = r_color;

`include "palette_nearest_color_matcher_defines.svh"

    `PNC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(ENTRIES), "count over depth")
    `PNC_ASSERT_NEXT(a_put_counts, i_clk, i_rst_n, r_state == S_IN_PUT, r_count == CW'($past(r_count) + 1'b1), "insert did not count")
    `PNC_ASSERT_NOW(a_bs_window, i_clk, i_rst_n, r_state == S_BS_CMP, (r_i0 < r_i) && (r_i < r_i1), "search probe outside window")
    `PNC_ASSERT_NOW(a_found_match, i_clk, i_rst_n, o_valid && o_found, r_cmd == CMD_MATCH, "found on non-match")

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking testbench for palette_nearest_color_matcher: directed table, then random
// requests checked by an in-bench palette model; depends on pnc_pkg and the block's rtl
`default_nettype none

module testbench
    import pnc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  pixel;
        logic        found;
        logic [17:0] distance;
        logic        alloc;
        logic [17:0] key_sum;
        logic [31:0] color_out;
    } t_res;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  pix;
        logic [31:0] argb;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        typed;
        t_res        res;
    } t_row;

    localparam t_res NO_RES = '0;
    localparam int N_DIR = 20;
    localparam t_row DIRECTED [N_DIR] = '{
        '{CMD_REVERSE, 8'd0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1,
          '{8'd0, 1'b0, 18'd0, 1'b0, 18'd0, COLOR_MISS}},
        '{CMD_MATCH, 8'd0, ARGB_BLACK, 16'h0, 16'h0, 16'h0, 1'b1,
          '{8'd0, 1'b0, DIST_NONE, 1'b0, 18'd0, 32'd0}},
        '{CMD_MATCH, 8'd0, ARGB_WHITE, 16'h0, 16'h0, 16'h0, 1'b1,
          '{8'd1, 1'b0, DIST_NONE, 1'b0, 18'd0, 32'd0}},
        // empty table: nothing selected, allocation wanted
        '{CMD_MATCH, 8'd0, 32'h0012_3456, 16'h0, 16'h0, 16'h0, 1'b1,
          '{8'd0, 1'b0, DIST_NONE, 1'b1, 18'd0, 32'd0}},
        '{CMD_NONE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, NO_RES},
        '{CMD_INSERT, 8'd0, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
          '{8'd0, 1'b0, 18'd0, 1'b0, 18'd196605, 32'd0}},
        // one entry and query sum above the window span
        '{CMD_MATCH, 8'd0, 32'h80FF_FFFF, 16'h0, 16'h0, 16'h0, 1'b0, NO_RES},
        '{CMD_MATCH, 8'd0, 32'h0000_0000, 16'h0, 16'h0, 16'h0, 1'b0, NO_RES},
        '{CMD_INSERT, 8'd255, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1, NO_RES},
        '{CMD_INSERT, 8'd7, 32'h0, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, NO_RES},
        '{CMD_INSERT, 8'd8, 32'h0, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, NO_RES},
        '{CMD_INSERT, 8'd9, 32'h0, 16'h3400, 16'h7800, 16'hBC00, 1'b0, NO_RES},
        '{CMD_MATCH, 8'd0, 32'h0034_78BC, 16'h0, 16'h0, 16'h0, 1'b0, NO_RES},
        '{CMD_MATCH, 8'd0, 32'h0012_3456, 16'h0, 16'h0, 16'h0, 1'b0, NO_RES},
        '{CMD_REVERSE, 8'd0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1,
          '{8'd0, 1'b0, 18'd0, 1'b0, 18'd0, 32'hFFFF_FFFF}},
        '{CMD_REVERSE, 8'd255, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1,
          '{8'd0, 1'b0, 18'd0, 1'b0, 18'd0, COLOR_MISS}},
        '{CMD_REVERSE, 8'd7, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0, NO_RES},
        '{CMD_MATCH, 8'd0, 32'h7F80_8080, 16'h0, 16'h0, 16'h0, 1'b0, NO_RES},
        '{CMD_INSERT, 8'd0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 1'b0, NO_RES},
        '{CMD_MATCH, 8'd0, 32'h0080_8080, 16'h0, 16'h0, 16'h0, 1'b0, NO_RES}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_cmd = '0;
    logic [7:0]  i_pixel_index = '0;
    logic [31:0] i_argb = '0;
    logic [15:0] i_entry_red = '0;
    logic [15:0] i_entry_green = '0;
    logic [15:0] i_entry_blue = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [17:0] i_cfg_wdata = '0;
    logic        o_busy, o_valid, o_found, o_alloc_wanted;
    logic [7:0]  o_pixel;
    logic [17:0] o_distance, o_key_sum;
    logic [31:0] o_color_out;

    always #1 i_clk = ~i_clk;

    palette_nearest_color_matcher dut (.*);

    // palette model state
    logic [7:0]  reg_black, reg_white;
    int unsigned reg_capacity, reg_span, reg_alloc;
    int unsigned entry_cnt;
    int unsigned key_mem [256];
    logic [7:0]  slot_mem [256];
    t_rgb        color_mem [256];
    bit          slot_written [256];

    t_res pending_results [$];
    int   errors = 0;

    function automatic int unsigned absdiff(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_res palette_step(t_row rq);
        t_res r;
        int unsigned qr, qg, qb, sum, hi, lo, i, i0, i1, s, d, mind, j;
        logic [7:0] best;
        bit got;
        r = '0;
        case (rq.cmd)
            CMD_MATCH: begin
                qr = {rq.argb[23:16], 8'h00};
                qg = {rq.argb[15:8], 8'h00};
                qb = {rq.argb[7:0], 8'h00};
                sum = qr + qg + qb;
                hi = sum + reg_span;
                if (rq.argb == ARGB_BLACK || rq.argb == ARGB_WHITE) begin
                    r.pixel = (rq.argb == ARGB_BLACK) ? reg_black : reg_white;
                    r.distance = DIST_NONE;
                    return r;
                end
                i = 0;
                got = 0;
                mind = 0;
                best = 0;
                if (sum > reg_span) begin
                    lo = sum - reg_span;
                    i0 = 0;
                    i1 = entry_cnt;
                    while (i1 - i0 > 1) begin
                        i = i0 + ((i1 - i0) >> 1);
                        if (key_mem[i] < lo) i0 = i;
                        else if (key_mem[i] == lo) break;
                        else i1 = i;
                    end
                    while (i > 0 && key_mem[i-1] == key_mem[i]) i--;
                end
                for (; i < entry_cnt; i++) begin
                    if (key_mem[i] > hi) break;
                    s = slot_mem[i];
                    d = absdiff(qr, color_mem[s].red) + absdiff(qg, color_mem[s].green)
                        + absdiff(qb, color_mem[s].blue);
                    if (d == 0) begin
                        mind = 0;
                        best = s[7:0];
                        got = 1;
                        break;
                    end
                    if (!got || d < mind) begin
                        mind = d;
                        best = s[7:0];
                        got = 1;
                    end
                end
                r.pixel = got ? best : 8'd0;
                r.found = got;
                r.distance = got ? mind[17:0] : DIST_NONE;
                r.alloc = (!got || mind > reg_alloc) && entry_cnt < reg_capacity;
            end
            CMD_INSERT: begin
                sum = rq.red + rq.green + rq.blue;
                r.key_sum = sum[17:0];
                color_mem[rq.pix] = '{rq.red, rq.green, rq.blue};
                slot_written[rq.pix] = 1;
                // full table: color stored, order list untouched
                if (entry_cnt < 256) begin
                    for (j = 0; j < entry_cnt; j++)
                        if (key_mem[j] > sum) break;
                    for (i = entry_cnt; i > j; i--) begin
                        key_mem[i] = key_mem[i-1];
                        slot_mem[i] = slot_mem[i-1];
                    end
                    key_mem[j] = sum;
                    slot_mem[j] = rq.pix;
                    entry_cnt++;
                end
            end
            CMD_REVERSE: begin
                r.color_out = COLOR_MISS;
                if (rq.pix < entry_cnt)
                    r.color_out = {8'hFF, color_mem[rq.pix].red[15:8],
                                   color_mem[rq.pix].green[15:8], color_mem[rq.pix].blue[15:8]};
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(t_row rq);
        t_res r;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_cmd <= rq.cmd;
        i_pixel_index <= rq.pix;
        i_argb <= rq.argb;
        i_entry_red <= rq.red;
        i_entry_green <= rq.green;
        i_entry_blue <= rq.blue;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        r = palette_step(rq);
        pending_results.push_back(rq.typed ? rq.res : r);
    endtask

    task automatic pause_start(int cycles);
        @(negedge i_clk);
        i_start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val[17:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BLACK:    reg_black = val[7:0];
            CFG_WHITE:    reg_white = val[7:0];
            CFG_CAPACITY: reg_capacity = val & 32'h1FF;
            CFG_SPAN:     reg_span = val & 32'h3FFFF;
            default:      reg_alloc = val & 32'h3FFFF;
        endcase
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_row random_request();
        t_row rq;
        int unsigned k, p, tries;
        t_rgb c;
        rq = '0;
        rq.pix = 8'($urandom);
        k = $urandom_range(99);
        if (k < 35) begin
            rq.cmd = CMD_INSERT;
            rq.red = 16'($urandom);
            rq.green = 16'($urandom);
            rq.blue = 16'($urandom);
            // byte-aligned colors give exact hits later
            if ($urandom_range(1)) begin
                rq.red[7:0] = 8'd0;
                rq.green[7:0] = 8'd0;
                rq.blue[7:0] = 8'd0;
            end
        end else if (k < 50) begin
            rq.cmd = CMD_REVERSE;
            if (entry_cnt < 256 && $urandom_range(3) == 0) begin
                rq.pix = 8'($urandom_range(255, entry_cnt));
            end else begin
                // only slots that hold a color may be read back
                rq.cmd = CMD_MATCH;
                for (tries = 0; tries < 16 && entry_cnt > 0; tries++) begin
                    p = $urandom_range(entry_cnt - 1);
                    if (slot_written[p]) begin
                        rq.cmd = CMD_REVERSE;
                        rq.pix = 8'(p);
                        break;
                    end
                end
            end
        end else if (k < 55) begin
            rq.cmd = CMD_NONE;
            rq.argb = $urandom;
            rq.red = 16'($urandom);
        end else begin
            rq.cmd = CMD_MATCH;
        end
        if (rq.cmd == CMD_MATCH) begin
            k = $urandom_range(9);
            rq.argb = $urandom;
            if (k == 0) begin
                rq.argb = $urandom_range(1) ? ARGB_BLACK : ARGB_WHITE;
            end else if (k < 5 && entry_cnt > 0) begin
                c = color_mem[slot_mem[$urandom_range(entry_cnt - 1)]];
                rq.argb[23:0] = {c.red[15:8], c.green[15:8], c.blue[15:8]};
            end
        end
        return rq;
    endfunction

    task automatic check_field(string name, longint unsigned exp, longint unsigned act);
        if (exp != act) begin
            $display("%0t: %s expected %0h actual %0h", $realtime, name, exp, act);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual pixel %0h key_sum %0h",
                         $realtime, o_pixel, o_key_sum);
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("pixel", e.pixel, o_pixel);
                check_field("found", e.found, o_found);
                check_field("distance", e.distance, o_distance);
                check_field("alloc_wanted", e.alloc, o_alloc_wanted);
                check_field("key_sum", e.key_sum, o_key_sum);
                check_field("color_out", e.color_out, o_color_out);
            end
        end
    end

    initial begin
        int unsigned n, ph, gap;
        reg_black = RST_BLACK;
        reg_white = RST_WHITE;
        reg_capacity = RST_CAPACITY;
        reg_span = RST_SPAN;
        reg_alloc = RST_ALLOC;
        entry_cnt = 0;
        foreach (slot_written[k]) slot_written[k] = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIR; k++) send_request(DIRECTED[k]);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                1: begin
                    write_reg(CFG_BLACK, 255);
                    write_reg(CFG_WHITE, 0);
                    write_reg(CFG_CAPACITY, 0);
                    write_reg(CFG_SPAN, 0);
                    write_reg(CFG_ALLOC, 0);
                end
                2: begin
                    write_reg(CFG_CAPACITY, 256);
                    write_reg(CFG_SPAN, 196605);
                    write_reg(CFG_ALLOC, 196605);
                end
                3, 4: begin
                    write_reg(CFG_BLACK, $urandom_range(255));
                    write_reg(CFG_WHITE, $urandom_range(255));
                    write_reg(CFG_CAPACITY, $urandom_range(256));
                    write_reg(CFG_SPAN, $urandom_range(60000));
                    write_reg(CFG_ALLOC, $urandom_range(40000));
                end
                5: begin
                    write_reg(CFG_CAPACITY, 256);
                    write_reg(CFG_SPAN, RST_SPAN);
                    write_reg(CFG_ALLOC, RST_ALLOC);
                end
                default: ;
            endcase
            for (n = 0; n < 322; n++) begin
                send_request(random_request());
                // idle bursts except near the end of the run
                if (!(ph == 5 && n > 200) && $urandom_range(5) == 0) begin
                    gap = $urandom_range(8, 1);
                    pause_start(gap);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/pnc_pkg.sv
rtl/pnc_key_store.sv
rtl/pnc_color_store.sv
rtl/pnc_dist.sv
rtl/palette_nearest_color_matcher.sv
verif/testbench.sv
